>>> design/best_fit_heap_allocator_defines.svh
// ----------------------------------------------------------------------------
// Best-fit heap allocator: assertion macros
// Shared macros for the concurrent checks of the allocator.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define BFHA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define BFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/bfha_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit heap allocator package
// Shared constants, status codes and the arithmetic unit's interface types.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int MAX_BLOCKS_DEF      = 256;
  localparam int FREE_LIST_DEPTH_DEF = 256;
  localparam int HEADER_BYTES_DEF    = 12;

  localparam int ALU_W = 26;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_UNINIT  = 3'd2,
    ST_NOFIT   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             lt;
    logic             eq;
  } alu_rsp_t;

endpackage

>>> design/best_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// Best-fit heap allocator
// Size-sorted free list with block splitting and coalescing of neighbours.
// ----------------------------------------------------------------------------
// The heap size is written over the cfg channel while the block is idle; a
// write rebuilds the heap as one free block, and zero leaves it uninitialised.
// Requests arrive on the in_ channel: tuser carries the opcode and the null
// flag, tdata the request size and the payload offset to release. Each
// request produces exactly one result transfer on the out_ channel carrying
// the status and the allocated payload offset.
// Requests are handled one at a time by a sequencer around a single adder and
// comparator. A payload size is found by reading a block's start and then the
// start of its successor (or the heap length) and subtracting the header end;
// a binary search halves the free list step by step, and an insert or a
// removal shifts list entries one by one. A free walks the block chain from
// the head one block at a time.
// Reset clears the heap to the uninitialised state. The result sits in an
// output register, so a stalled receiver holds only the next result: the block
// waits until that register is free, then returns to idle for a new request.
module best_fit_heap_allocator #(
  parameter int MAX_BLOCKS      = bfha_pkg::MAX_BLOCKS_DEF,
  parameter int FREE_LIST_DEPTH = bfha_pkg::FREE_LIST_DEPTH_DEF,
  parameter int HEADER_BYTES    = bfha_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // request_bytes[23:0], payload_offset[47:24]
  input  logic [1:0]  in_tuser,  // opcode[0], is_null[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata  // status[2:0], result_offset[26:3], zero[31:27]
);

  localparam int AW  = $clog2(MAX_BLOCKS);
  localparam int LNK = AW + 1;
  localparam int PCW = $clog2(MAX_BLOCKS + 1);
  localparam int LW  = $clog2(FREE_LIST_DEPTH);
  localparam int CW  = $clog2(FREE_LIST_DEPTH + 1);
  localparam int AL  = bfha_pkg::ALU_W;

  localparam logic [LNK-1:0] NO_BLK = LNK'(MAX_BLOCKS);
  localparam logic [AL-1:0]  HDR    = AL'(HEADER_BYTES);

  typedef enum logic [36:0] {
    S_IDLE    = 37'b1 << 0,
    S_A_CHK   = 37'b1 << 1,
    S_A_LB    = 37'b1 << 2,
    S_A_IDX   = 37'b1 << 3,
    S_A_B     = 37'b1 << 4,
    S_A_SZ    = 37'b1 << 5,
    S_A_POST  = 37'b1 << 6,
    S_A_POP   = 37'b1 << 7,
    S_A_LINK  = 37'b1 << 8,
    S_F_CHK   = 37'b1 << 9,
    S_F_RD    = 37'b1 << 10,
    S_F_CMP   = 37'b1 << 11,
    S_F_NX    = 37'b1 << 12,
    S_F_PV    = 37'b1 << 13,
    S_F_DEC   = 37'b1 << 14,
    S_F_MN    = 37'b1 << 15,
    S_F_P     = 37'b1 << 16,
    S_F_MP    = 37'b1 << 17,
    S_P0      = 37'b1 << 18,
    S_P1      = 37'b1 << 19,
    S_P2      = 37'b1 << 20,
    S_P3      = 37'b1 << 21,
    S_LB_TEST = 37'b1 << 22,
    S_LB_RD   = 37'b1 << 23,
    S_LB_CMP  = 37'b1 << 24,
    S_RM_RD   = 37'b1 << 25,
    S_RM_WR   = 37'b1 << 26,
    S_INS_GO  = 37'b1 << 27,
    S_INS_LB  = 37'b1 << 28,
    S_INS_RD  = 37'b1 << 29,
    S_INS_WR  = 37'b1 << 30,
    S_RB_GO   = 37'b1 << 31,
    S_RB_LB   = 37'b1 << 32,
    S_RB_RD   = 37'b1 << 33,
    S_RB_CHK  = 37'b1 << 34,
    S_RB_CMP  = 37'b1 << 35,
    S_FIN     = 37'b1 << 36
  } state_t;

  typedef struct packed {
    logic [23:0]       req;
    logic [23:0]       poff;
    logic              is_null;
    logic [24:0]       padded;
    logic [AW-1:0]     b;
    logic [23:0]       b_start;
    logic [LNK-1:0]    b_next;
    logic              split;
    logic [23:0]       off;
    bfha_pkg::status_t st;
    logic [AW-1:0]     r;
    logic [AW-1:0]     s;
    logic [AW-1:0]     n;
    logic [LNK-1:0]    nx;
    logic [LNK-1:0]    pv;
    logic [LNK-1:0]    nnx;
    logic [LNK-1:0]    nn;
    logic              nf;
    logic              pf;
    logic [AW-1:0]     ps_s;
    logic [23:0]       ps_start;
    logic [LNK-1:0]    ps_next;
    logic [24:0]       low;
    logic [23:0]       end_b;
    logic [23:0]       size;
    logic [CW-1:0]     lo;
    logic [CW-1:0]     hi;
    logic [CW-1:0]     mid;
    logic [24:0]       want;
    logic [CW-1:0]     k;
    logic [AW-1:0]     ins_s;
    logic [AW-1:0]     rb_s;
    logic [23:0]       rb_sz;
    state_t            ps_ret;
    state_t            lb_ret;
    state_t            rm_ret;
    state_t            ins_ret;
    state_t            rb_ret;
  } ctx_t;

  state_t state_r, state_nxt;
  ctx_t   ctx_r, ctx_nxt;

  logic [23:0]   heap_len_r, heap_len_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] list_cnt_r, list_cnt_nxt;
  logic [PCW-1:0] pool_cnt_r, pool_cnt_nxt;
  logic [PCW-1:0] pool_min_r, pool_min_nxt;

  logic              out_valid_r, out_valid_nxt;
  bfha_pkg::status_t out_status_r, out_status_nxt;
  logic [23:0]       out_off_r, out_off_nxt;

  logic [23:0]    start_mem [MAX_BLOCKS];
  logic [LNK-1:0] next_mem  [MAX_BLOCKS];
  logic [LNK-1:0] prev_mem  [MAX_BLOCKS];
  logic           used_mem  [MAX_BLOCKS];
  logic [AW-1:0]  pool_mem  [MAX_BLOCKS];
  logic [AW-1:0]  list_mem  [FREE_LIST_DEPTH];

  logic [AW-1:0]  ba;
  logic [23:0]    bq_start;
  logic [LNK-1:0] bq_next, bq_prev;
  logic           bq_used;
  logic           st_we, nx_we, pv_we, us_we, pl_we, ls_we;
  logic [AW-1:0]  st_wa, nx_wa, pv_wa, us_wa, pl_wa, pl_ra;
  logic [23:0]    st_wd;
  logic [LNK-1:0] nx_wd, pv_wd;
  logic           us_wd;
  logic [AW-1:0]  pl_wd, pl_q, ls_wd, ls_q;
  logic [LW-1:0]  ls_wa, ls_ra;

  bfha_pkg::alu_req_t alu_req;
  bfha_pkg::alu_rsp_t alu_rsp;

  logic [PCW-1:0] pop_j;
  logic [AW-1:0]  pop_slot;
  logic           pf_now;

  bfha_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (st_we) start_mem[st_wa] <= st_wd;
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (us_we) used_mem[us_wa] <= us_wd;
    bq_start <= start_mem[ba];
    bq_next  <= next_mem[ba];
    bq_prev  <= prev_mem[ba];
    bq_used  <= used_mem[ba];
  end

  always_ff @(posedge clk) begin
    if (pl_we) pool_mem[pl_wa] <= pl_wd;
    pl_q <= pool_mem[pl_ra];
  end

  always_ff @(posedge clk) begin
    if (ls_we) list_mem[ls_wa] <= ls_wd;
    ls_q <= list_mem[ls_ra];
  end

  assign pop_j    = pool_cnt_r - PCW'(1);
  assign pop_slot = (pop_j < pool_min_r) ? (AW'(MAX_BLOCKS - 1) - AW'(pop_j)) : pl_q;
  assign pf_now   = (ctx_r.pv != NO_BLK) && !bq_used;

  always_comb begin
    state_nxt      = state_r;
    ctx_nxt        = ctx_r;
    heap_len_nxt   = heap_len_r;
    head_nxt       = head_r;
    list_cnt_nxt   = list_cnt_r;
    pool_cnt_nxt   = pool_cnt_r;
    pool_min_nxt   = pool_min_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    alu_req        = '0;
    ba             = '0;
    st_we = 1'b0; st_wa = '0; st_wd = '0;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    us_we = 1'b0; us_wa = '0; us_wd = 1'b0;
    pl_we = 1'b0; pl_wa = '0; pl_wd = '0; pl_ra = '0;
    ls_we = 1'b0; ls_wa = '0; ls_wd = '0; ls_ra = '0;

    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          heap_len_nxt = cfg_data;
          list_cnt_nxt = '0;
          pool_cnt_nxt = PCW'(MAX_BLOCKS);
          pool_min_nxt = PCW'(MAX_BLOCKS);
          head_nxt     = '0;
          if (cfg_data != 24'd0) begin
            st_we = 1'b1; st_wa = '0; st_wd = '0;
            nx_we = 1'b1; nx_wa = '0; nx_wd = NO_BLK;
            pv_we = 1'b1; pv_wa = '0; pv_wd = NO_BLK;
            us_we = 1'b1; us_wa = '0; us_wd = 1'b0;
            ls_we = 1'b1; ls_wa = '0; ls_wd = '0;
            list_cnt_nxt = CW'(1);
            pool_cnt_nxt = PCW'(MAX_BLOCKS - 1);
            pool_min_nxt = PCW'(MAX_BLOCKS - 1);
          end
        end else if (in_tvalid) begin
          ctx_nxt.req     = in_tdata[23:0];
          ctx_nxt.poff    = in_tdata[47:24];
          ctx_nxt.is_null = in_tuser[1];
          ctx_nxt.off     = '0;
          state_nxt = (in_tuser[0] == bfha_pkg::OP_FREE) ? S_F_CHK : S_A_CHK;
        end
      end

      S_A_CHK: begin
        alu_req.a = AL'(ctx_r.req);
        alu_req.b = AL'(3);
        ctx_nxt.padded = {alu_rsp.res[24:2], 2'b00};
        if (ctx_r.req == 24'd0) begin
          ctx_nxt.st = bfha_pkg::ST_INVALID;
          state_nxt  = S_FIN;
        end else if (heap_len_r == 24'd0) begin
          ctx_nxt.st = bfha_pkg::ST_UNINIT;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_A_LB;
        end
      end

      S_A_LB: begin
        ctx_nxt.want   = ctx_r.padded;
        ctx_nxt.lo     = '0;
        ctx_nxt.hi     = list_cnt_r;
        ctx_nxt.lb_ret = S_A_IDX;
        state_nxt      = S_LB_TEST;
      end

      S_A_IDX: begin
        if (ctx_r.lo >= list_cnt_r) begin
          ctx_nxt.st = bfha_pkg::ST_NOFIT;
          state_nxt  = S_FIN;
        end else begin
          ls_ra     = LW'(ctx_r.lo);
          state_nxt = S_A_B;
        end
      end

      S_A_B: begin
        ctx_nxt.b      = ls_q;
        ctx_nxt.ps_s   = ls_q;
        ctx_nxt.ps_ret = S_A_SZ;
        state_nxt      = S_P0;
      end

      S_A_SZ: begin
        ctx_nxt.b_start = ctx_r.ps_start;
        ctx_nxt.b_next  = ctx_r.ps_next;
        alu_req.sub = 1'b1;
        alu_req.a   = AL'(ctx_r.size);
        alu_req.b   = AL'(ctx_r.padded);
        alu_req.c   = HDR + AL'(1);
        ctx_nxt.split = !alu_rsp.lt;
        if (!alu_rsp.lt && (pool_cnt_r == '0)) begin
          ctx_nxt.st = bfha_pkg::ST_FULL;
          state_nxt  = S_FIN;
        end else begin
          ctx_nxt.k      = ctx_r.lo;
          ctx_nxt.rm_ret = S_A_POST;
          state_nxt      = S_RM_RD;
        end
      end

      S_A_POST: begin
        alu_req.a   = AL'(ctx_r.b_start);
        alu_req.b   = HDR;
        ctx_nxt.off = alu_rsp.res[23:0];
        ctx_nxt.st  = bfha_pkg::ST_OK;
        if (!ctx_r.split) begin
          us_we = 1'b1; us_wa = ctx_r.b; us_wd = 1'b1;
          state_nxt = S_FIN;
        end else begin
          pl_ra     = AW'(pop_j);
          state_nxt = S_A_POP;
        end
      end

      S_A_POP: begin
        pool_cnt_nxt = pop_j;
        if (pop_j < pool_min_r) pool_min_nxt = pop_j;
        alu_req.a = AL'(ctx_r.off);
        alu_req.b = AL'(ctx_r.padded);
        st_we = 1'b1; st_wa = pop_slot; st_wd = alu_rsp.res[23:0];
        pv_we = 1'b1; pv_wa = pop_slot; pv_wd = {1'b0, ctx_r.b};
        nx_we = 1'b1; nx_wa = pop_slot; nx_wd = ctx_r.b_next;
        us_we = 1'b1; us_wa = pop_slot; us_wd = 1'b0;
        ctx_nxt.r = pop_slot;
        state_nxt = S_A_LINK;
      end

      S_A_LINK: begin
        if (ctx_r.b_next != NO_BLK) begin
          pv_we = 1'b1; pv_wa = AW'(ctx_r.b_next); pv_wd = {1'b0, ctx_r.r};
        end
        nx_we = 1'b1; nx_wa = ctx_r.b; nx_wd = {1'b0, ctx_r.r};
        us_we = 1'b1; us_wa = ctx_r.b; us_wd = 1'b1;
        ctx_nxt.ins_s   = ctx_r.r;
        ctx_nxt.ins_ret = S_FIN;
        state_nxt       = S_INS_GO;
      end

      S_F_CHK: begin
        if (ctx_r.is_null) begin
          ctx_nxt.st = bfha_pkg::ST_OK;
          state_nxt  = S_FIN;
        end else if (heap_len_r == 24'd0) begin
          ctx_nxt.st = bfha_pkg::ST_UNINIT;
          state_nxt  = S_FIN;
        end else begin
          ctx_nxt.s = head_r;
          state_nxt = S_F_RD;
        end
      end

      S_F_RD: begin
        ba        = ctx_r.s;
        state_nxt = S_F_CMP;
      end

      S_F_CMP: begin
        alu_req.a = AL'(bq_start);
        alu_req.b = HDR;
        alu_req.c = AL'(ctx_r.poff);
        if (bq_used && alu_rsp.eq) begin
          ctx_nxt.n  = ctx_r.s;
          ctx_nxt.nx = bq_next;
          ctx_nxt.pv = bq_prev;
          state_nxt  = S_F_NX;
        end else if (bq_next == NO_BLK) begin
          ctx_nxt.st = bfha_pkg::ST_INVALID;
          state_nxt  = S_FIN;
        end else begin
          ctx_nxt.s = AW'(bq_next);
          state_nxt = S_F_RD;
        end
      end

      S_F_NX: begin
        ba        = AW'(ctx_r.nx);
        state_nxt = S_F_PV;
      end

      S_F_PV: begin
        ctx_nxt.nf  = (ctx_r.nx != NO_BLK) && !bq_used;
        ctx_nxt.nnx = bq_next;
        ba          = AW'(ctx_r.pv);
        state_nxt   = S_F_DEC;
      end

      S_F_DEC: begin
        if (!ctx_r.nf && !pf_now && (list_cnt_r >= CW'(FREE_LIST_DEPTH))) begin
          ctx_nxt.st = bfha_pkg::ST_FULL;
          state_nxt  = S_FIN;
        end else begin
          ctx_nxt.pf = pf_now;
          ctx_nxt.st = bfha_pkg::ST_OK;
          ctx_nxt.nn = ctx_r.nx;
          us_we = 1'b1; us_wa = ctx_r.n; us_wd = 1'b0;
          if (ctx_r.nf) begin
            ctx_nxt.rb_s   = AW'(ctx_r.nx);
            ctx_nxt.rb_ret = S_F_MN;
            state_nxt      = S_RB_GO;
          end else begin
            state_nxt = S_F_P;
          end
        end
      end

      S_F_MN: begin
        nx_we = 1'b1; nx_wa = ctx_r.n; nx_wd = ctx_r.nnx;
        ctx_nxt.nn = ctx_r.nnx;
        if (ctx_r.nnx != NO_BLK) begin
          pv_we = 1'b1; pv_wa = AW'(ctx_r.nnx); pv_wd = {1'b0, ctx_r.n};
        end
        if (pool_cnt_r < PCW'(MAX_BLOCKS)) begin
          pl_we = 1'b1; pl_wa = AW'(pool_cnt_r); pl_wd = AW'(ctx_r.nx);
          pool_cnt_nxt = pool_cnt_r + PCW'(1);
        end
        state_nxt = S_F_P;
      end

      S_F_P: begin
        if (ctx_r.pf) begin
          ctx_nxt.rb_s   = AW'(ctx_r.pv);
          ctx_nxt.rb_ret = S_F_MP;
          state_nxt      = S_RB_GO;
        end else begin
          ctx_nxt.ins_s   = ctx_r.n;
          ctx_nxt.ins_ret = S_FIN;
          state_nxt       = S_INS_GO;
        end
      end

      S_F_MP: begin
        nx_we = 1'b1; nx_wa = AW'(ctx_r.pv); nx_wd = ctx_r.nn;
        if (ctx_r.nn != NO_BLK) begin
          pv_we = 1'b1; pv_wa = AW'(ctx_r.nn); pv_wd = ctx_r.pv;
        end
        if (pool_cnt_r < PCW'(MAX_BLOCKS)) begin
          pl_we = 1'b1; pl_wa = AW'(pool_cnt_r); pl_wd = ctx_r.n;
          pool_cnt_nxt = pool_cnt_r + PCW'(1);
        end
        ctx_nxt.n       = AW'(ctx_r.pv);
        ctx_nxt.ins_s   = AW'(ctx_r.pv);
        ctx_nxt.ins_ret = S_FIN;
        state_nxt       = S_INS_GO;
      end

      S_P0: begin
        ba        = ctx_r.ps_s;
        state_nxt = S_P1;
      end

      S_P1: begin
        ctx_nxt.ps_start = bq_start;
        ctx_nxt.ps_next  = bq_next;
        alu_req.a   = AL'(bq_start);
        alu_req.b   = HDR;
        ctx_nxt.low = alu_rsp.res[24:0];
        ba          = AW'(bq_next);
        state_nxt   = S_P2;
      end

      S_P2: begin
        ctx_nxt.end_b = (ctx_r.ps_next == NO_BLK) ? heap_len_r : bq_start;
        state_nxt     = S_P3;
      end

      S_P3: begin
        alu_req.sub  = 1'b1;
        alu_req.a    = AL'(ctx_r.end_b);
        alu_req.b    = AL'(ctx_r.low);
        ctx_nxt.size = alu_rsp.res[AL-1] ? 24'd0 : alu_rsp.res[23:0];
        state_nxt    = ctx_r.ps_ret;
      end

      S_LB_TEST: begin
        if (ctx_r.lo < ctx_r.hi) begin
          ctx_nxt.mid = CW'(((CW+1)'(ctx_r.lo) + (CW+1)'(ctx_r.hi)) >> 1);
          ls_ra       = LW'(((CW+1)'(ctx_r.lo) + (CW+1)'(ctx_r.hi)) >> 1);
          state_nxt   = S_LB_RD;
        end else begin
          state_nxt = ctx_r.lb_ret;
        end
      end

      S_LB_RD: begin
        ctx_nxt.ps_s   = ls_q;
        ctx_nxt.ps_ret = S_LB_CMP;
        state_nxt      = S_P0;
      end

      S_LB_CMP: begin
        alu_req.a = AL'(ctx_r.size);
        alu_req.c = AL'(ctx_r.want);
        if (alu_rsp.lt) ctx_nxt.lo = ctx_r.mid + CW'(1);
        else            ctx_nxt.hi = ctx_r.mid;
        state_nxt = S_LB_TEST;
      end

      S_RM_RD: begin
        if ((ctx_r.k + CW'(1)) < list_cnt_r) begin
          ls_ra     = LW'(ctx_r.k + CW'(1));
          state_nxt = S_RM_WR;
        end else begin
          list_cnt_nxt = list_cnt_r - CW'(1);
          state_nxt    = ctx_r.rm_ret;
        end
      end

      S_RM_WR: begin
        ls_we = 1'b1; ls_wa = LW'(ctx_r.k); ls_wd = ls_q;
        ctx_nxt.k = ctx_r.k + CW'(1);
        state_nxt = S_RM_RD;
      end

      S_INS_GO: begin
        if (list_cnt_r >= CW'(FREE_LIST_DEPTH)) begin
          state_nxt = ctx_r.ins_ret;
        end else begin
          ctx_nxt.ps_s   = ctx_r.ins_s;
          ctx_nxt.ps_ret = S_INS_LB;
          state_nxt      = S_P0;
        end
      end

      S_INS_LB: begin
        ctx_nxt.want   = {1'b0, ctx_r.size};
        ctx_nxt.lo     = '0;
        ctx_nxt.hi     = list_cnt_r;
        ctx_nxt.k      = list_cnt_r;
        ctx_nxt.lb_ret = S_INS_RD;
        state_nxt      = S_LB_TEST;
      end

      S_INS_RD: begin
        if (ctx_r.k > ctx_r.lo) begin
          ls_ra     = LW'(ctx_r.k - CW'(1));
          state_nxt = S_INS_WR;
        end else begin
          ls_we = 1'b1; ls_wa = LW'(ctx_r.lo); ls_wd = ctx_r.ins_s;
          list_cnt_nxt = list_cnt_r + CW'(1);
          state_nxt    = ctx_r.ins_ret;
        end
      end

      S_INS_WR: begin
        ls_we = 1'b1; ls_wa = LW'(ctx_r.k); ls_wd = ls_q;
        ctx_nxt.k = ctx_r.k - CW'(1);
        state_nxt = S_INS_RD;
      end

      S_RB_GO: begin
        ctx_nxt.ps_s   = ctx_r.rb_s;
        ctx_nxt.ps_ret = S_RB_LB;
        state_nxt      = S_P0;
      end

      S_RB_LB: begin
        ctx_nxt.rb_sz  = ctx_r.size;
        ctx_nxt.want   = {1'b0, ctx_r.size};
        ctx_nxt.lo     = '0;
        ctx_nxt.hi     = list_cnt_r;
        ctx_nxt.lb_ret = S_RB_RD;
        state_nxt      = S_LB_TEST;
      end

      S_RB_RD: begin
        if (ctx_r.lo < list_cnt_r) begin
          ls_ra     = LW'(ctx_r.lo);
          state_nxt = S_RB_CHK;
        end else begin
          state_nxt = ctx_r.rb_ret;
        end
      end

      S_RB_CHK: begin
        if (ls_q == ctx_r.rb_s) begin
          ctx_nxt.k      = ctx_r.lo;
          ctx_nxt.rm_ret = ctx_r.rb_ret;
          state_nxt      = S_RM_RD;
        end else begin
          ctx_nxt.ps_s   = ls_q;
          ctx_nxt.ps_ret = S_RB_CMP;
          state_nxt      = S_P0;
        end
      end

      S_RB_CMP: begin
        alu_req.a = AL'(ctx_r.size);
        alu_req.c = AL'(ctx_r.rb_sz);
        if (alu_rsp.eq) begin
          ctx_nxt.lo = ctx_r.lo + CW'(1);
          state_nxt  = S_RB_RD;
        end else begin
          state_nxt = ctx_r.rb_ret;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ctx_r.st;
          out_off_nxt    = (ctx_r.st == bfha_pkg::ST_OK) ? ctx_r.off : 24'd0;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      heap_len_r  <= '0;
      head_r      <= '0;
      list_cnt_r  <= '0;
      pool_cnt_r  <= PCW'(MAX_BLOCKS);
      pool_min_r  <= PCW'(MAX_BLOCKS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      heap_len_r  <= heap_len_nxt;
      head_r      <= head_nxt;
      list_cnt_r  <= list_cnt_nxt;
      pool_cnt_r  <= pool_cnt_nxt;
      pool_min_r  <= pool_min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r        <= ctx_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
  end

  assign cfg_ready  = (state_r == S_IDLE);
  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_off_r, out_status_r};

  `include "best_fit_heap_allocator_defines.svh"

  `BFHA_ASSERT_ALWAYS(a_pool_floor, pool_min_r <= pool_cnt_r, "pool count fell below its low mark")
  `BFHA_ASSERT_ALWAYS(a_list_bound, list_cnt_r <= CW'(FREE_LIST_DEPTH), "free list overflow")
  `BFHA_ASSERT_NEXT(a_busy, in_tvalid && in_tready, !in_tready && !cfg_ready, "request overlap")
  `BFHA_ASSERT_NEXT(a_init, cfg_valid && cfg_ready && (cfg_data != 24'd0), (list_cnt_r == CW'(1)) && (pool_cnt_r == PCW'(MAX_BLOCKS - 1)), "heap rebuild wrong")

endmodule

>>> design/bfha_alu.sv
// ----------------------------------------------------------------------------
// Best-fit heap allocator: shared arithmetic unit
// One add or subtract followed by a compare of the result against a third operand.
// ----------------------------------------------------------------------------
module bfha_alu (
  input  bfha_pkg::alu_req_t req,
  output bfha_pkg::alu_rsp_t rsp
);

  logic [bfha_pkg::ALU_W-1:0] sum;

  assign sum     = req.sub ? (req.a - req.b) : (req.a + req.b);
  assign rsp.res = sum;
  assign rsp.lt  = (sum < req.c);
  assign rsp.eq  = (sum == req.c);

endmodule

>>> tb/tb_best_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// Best-fit heap allocator testbench
// Drives allocate and free requests under varying heap sizes and handshake
// pressure, predicts every status and payload offset, and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_best_fit_heap_allocator;

  localparam int NBLK = bfha_pkg::MAX_BLOCKS_DEF;
  localparam int LDEPTH = bfha_pkg::FREE_LIST_DEPTH_DEF;
  localparam int HDR = bfha_pkg::HEADER_BYTES_DEF;
  localparam int STALL_LIMIT = 40000;

  class heap_scoreboard;
    int unsigned hlen;
    int unsigned bstart[NBLK];
    int unsigned bnext[NBLK];
    int unsigned bprev[NBLK];
    bit          bused[NBLK];
    int unsigned pool[NBLK];
    int unsigned pcount;
    int unsigned flist[LDEPTH];
    int unsigned fcount;
    int unsigned head;
    bfha_pkg::status_t exp_status[$];
    logic [23:0] exp_off[$];
    bfha_pkg::status_t last_status;
    int unsigned last_off;
    int          errors;
    int          status_seen[5];

    function int unsigned psize(int unsigned s);
      int unsigned stop;
      int unsigned low;
      stop = (bnext[s] == NBLK) ? hlen : bstart[bnext[s]];
      low = bstart[s] + HDR;
      return (stop > low) ? stop - low : 0;
    endfunction

    function int unsigned lbound(int unsigned want);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = fcount;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (psize(flist[mid]) < want) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function void remove_at(int unsigned i);
      if (i >= fcount) return;
      for (int unsigned k = i; k + 1 < fcount; k++) flist[k] = flist[k + 1];
      fcount--;
    endfunction

    function void insert(int unsigned s);
      int unsigned i;
      if (fcount >= LDEPTH) return;
      i = lbound(psize(s));
      for (int unsigned k = fcount; k > i; k--) flist[k] = flist[k - 1];
      flist[i] = s;
      fcount++;
    endfunction

    function void remove_block(int unsigned s);
      int unsigned sz;
      sz = psize(s);
      for (int unsigned i = lbound(sz); i < fcount && psize(flist[i]) == sz; i++) begin
        if (flist[i] == s) begin
          remove_at(i);
          return;
        end
      end
    endfunction

    function void configure(logic [23:0] len);
      for (int i = 0; i < NBLK; i++) begin
        bstart[i] = 0;
        bnext[i] = 0;
        bprev[i] = 0;
        bused[i] = 0;
        pool[i] = NBLK - 1 - i;
      end
      pcount = NBLK;
      fcount = 0;
      head = 0;
      hlen = 32'(len);
      if (hlen == 0) return;
      pcount--;
      head = pool[pcount];
      bstart[head] = 0;
      bnext[head] = NBLK;
      bprev[head] = NBLK;
      insert(head);
    endfunction

    function bfha_pkg::status_t alloc(int unsigned req, output int unsigned off);
      int unsigned padded;
      int unsigned idx;
      int unsigned sz;
      int unsigned b;
      int unsigned r;
      off = 0;
      if (req == 0) return bfha_pkg::ST_INVALID;
      if (hlen == 0) return bfha_pkg::ST_UNINIT;
      padded = (req + 3) & ~32'd3;
      idx = lbound(padded);
      if (idx >= fcount) return bfha_pkg::ST_NOFIT;
      b = flist[idx];
      sz = psize(b);
      if (sz - padded > HDR) begin
        if (pcount == 0) return bfha_pkg::ST_FULL;
        remove_at(idx);
        pcount--;
        r = pool[pcount];
        bstart[r] = bstart[b] + HDR + padded;
        bprev[r] = b;
        bnext[r] = bnext[b];
        bused[r] = 0;
        if (bnext[b] != NBLK) bprev[bnext[b]] = r;
        bnext[b] = r;
        insert(r);
      end else begin
        remove_at(idx);
      end
      bused[b] = 1;
      off = (bstart[b] + HDR) & 24'hFFFFFF;
      return bfha_pkg::ST_OK;
    endfunction

    function bfha_pkg::status_t free_block(int unsigned poff, bit nul);
      int unsigned n;
      int unsigned s;
      int unsigned nx;
      int unsigned pv;
      bit nfree;
      bit pfree;
      if (nul) return bfha_pkg::ST_OK;
      if (hlen == 0) return bfha_pkg::ST_UNINIT;
      n = NBLK;
      s = head;
      for (int steps = 0; s != NBLK && steps < NBLK; steps++) begin
        if (bused[s] && bstart[s] + HDR == poff) begin
          n = s;
          break;
        end
        s = bnext[s];
      end
      if (n == NBLK) return bfha_pkg::ST_INVALID;
      nx = bnext[n];
      pv = bprev[n];
      nfree = (nx != NBLK) && !bused[nx];
      pfree = (pv != NBLK) && !bused[pv];
      if (!nfree && !pfree && fcount >= LDEPTH) return bfha_pkg::ST_FULL;
      bused[n] = 0;
      if (nfree) begin
        remove_block(nx);
        bnext[n] = bnext[nx];
        if (bnext[n] != NBLK) bprev[bnext[n]] = n;
        if (pcount < NBLK) begin
          pool[pcount] = nx;
          pcount++;
        end
      end
      if (pfree) begin
        remove_block(pv);
        bnext[pv] = bnext[n];
        if (bnext[n] != NBLK) bprev[bnext[n]] = pv;
        if (pcount < NBLK) begin
          pool[pcount] = n;
          pcount++;
        end
        n = pv;
      end
      insert(n);
      return bfha_pkg::ST_OK;
    endfunction

    function void note_request(bfha_pkg::opcode_t op, logic [23:0] req, logic [23:0] poff,
                               bit nul);
      int unsigned off;
      off = 0;
      if (op == bfha_pkg::OP_ALLOC) last_status = alloc(32'(req), off);
      else last_status = free_block(32'(poff), nul);
      if (last_status != bfha_pkg::ST_OK) off = 0;
      last_off = off;
      exp_status = {exp_status, last_status};
      exp_off = {exp_off, off[23:0]};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    endtask

    task check_result(logic [31:0] data);
      bfha_pkg::status_t want_st;
      logic [23:0]       want_off;
      if (exp_status.size() == 0) begin
        report("unexpected result", data, 0);
        return;
      end
      want_st = exp_status.pop_front();
      want_off = exp_off.pop_front();
      if (want_st <= bfha_pkg::ST_FULL) status_seen[want_st]++;
      if (data[2:0] !== want_st) report("status", 32'(data[2:0]), 32'(want_st));
      if (data[26:3] !== want_off) report("result_offset", 32'(data[26:3]), 32'(want_off));
    endtask

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [23:0] cfg_data = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = 0;
  logic [1:0]  in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;

  heap_scoreboard sb = new();
  int unsigned live_offs[$];
  int unsigned freed_offs[$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int items_sent = 0;
  int configs_written = 0;

  best_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", stall_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task send_req(bfha_pkg::opcode_t op, logic [23:0] req, logic [23:0] poff, bit nul);
    int idx;
    in_tvalid <= 1'b1;
    in_tdata <= {poff, req};
    in_tuser <= {nul, op};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, req, poff, nul);
    items_sent++;
    if (sb.last_status == bfha_pkg::ST_OK && op == bfha_pkg::OP_ALLOC)
      live_offs = {live_offs, sb.last_off};
    if (sb.last_status == bfha_pkg::ST_OK && op == bfha_pkg::OP_FREE && !nul) begin
      for (idx = 0; idx < live_offs.size(); idx++)
        if (live_offs[idx] == poff) break;
      if (idx < live_offs.size()) live_offs.delete(idx);
      freed_offs = {freed_offs, 32'(poff)};
      if (freed_offs.size() > 16) void'(freed_offs.pop_front());
    end
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task drain();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_heap_length(logic [23:0] len);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.configure(len);
    live_offs.delete();
    freed_offs.delete();
    configs_written++;
  endtask

  task random_req(int alloc_pct);
    int r;
    int unsigned sz;
    r = $urandom_range(99);
    if (r < alloc_pct || live_offs.size() == 0 && r < 90) begin
      case ($urandom_range(49))
        0:               sz = $urandom_range(24'hFFFFFF);
        1, 2, 3, 4:      sz = $urandom_range(sb.hlen / 4 + 1, 1);
        5, 6, 7, 8, 9,
        10, 11, 12, 13:  sz = $urandom_range(1024, 65);
        default:         sz = $urandom_range(64, 1);
      endcase
      send_req(bfha_pkg::OP_ALLOC, sz[23:0], 24'($urandom_range(24'hFFFFFF)),
               1'($urandom_range(1)));
    end else if (r < 93 && live_offs.size() > 0) begin
      send_req(bfha_pkg::OP_FREE, 24'($urandom_range(24'hFFFFFF)),
               24'(live_offs[$urandom_range(live_offs.size() - 1)]), 1'b0);
    end else begin
      case ($urandom_range(3))
        0: send_req(bfha_pkg::OP_FREE, 24'($urandom_range(24'hFFFFFF)),
                    24'($urandom_range(24'hFFFFFF)), 1'b1);
        1: send_req(bfha_pkg::OP_ALLOC, 24'd0, 24'($urandom_range(24'hFFFFFF)),
                    1'($urandom_range(1)));
        2: send_req(bfha_pkg::OP_FREE, 24'd0, 24'($urandom_range(24'hFFFFFF)), 1'b0);
        default: send_req(bfha_pkg::OP_FREE, 24'd0,
                          24'(freed_offs.size() > 0
                              ? freed_offs[$urandom_range(freed_offs.size() - 1)]
                              : $urandom_range(64) * 4), 1'b0);
      endcase
    end
  endtask

  initial begin
    int unsigned len;
    sb.configure(24'd0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(bfha_pkg::OP_ALLOC, 24'd16, 24'd0, 1'b0);
    send_req(bfha_pkg::OP_FREE, 24'd0, 24'd100, 1'b0);
    send_req(bfha_pkg::OP_FREE, 24'd0, 24'hFFFFFF, 1'b1);
    send_req(bfha_pkg::OP_ALLOC, 24'd0, 24'd0, 1'b0);

    write_heap_length(24'd4096);
    send_req(bfha_pkg::OP_ALLOC, 24'd1, 24'd0, 1'b0);
    send_req(bfha_pkg::OP_ALLOC, 24'd0, 24'd0, 1'b0);
    send_req(bfha_pkg::OP_ALLOC, 24'hFFFFFF, 24'd0, 1'b0);
    send_req(bfha_pkg::OP_ALLOC, 24'd100, 24'd0, 1'b1);
    send_req(bfha_pkg::OP_FREE, 24'd0, 24'd12, 1'b0);
    send_req(bfha_pkg::OP_FREE, 24'd0, 24'd12, 1'b0);
    send_req(bfha_pkg::OP_FREE, 24'd0, 24'hFFFFFF, 1'b0);
    send_req(bfha_pkg::OP_FREE, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_req(bfha_pkg::OP_ALLOC, 24'd3948, 24'd0, 1'b0);

    write_heap_length(24'd8);
    send_req(bfha_pkg::OP_ALLOC, 24'd1, 24'd0, 1'b0);
    write_heap_length(24'd12);
    send_req(bfha_pkg::OP_ALLOC, 24'd4, 24'd0, 1'b0);
    write_heap_length(24'd16);
    send_req(bfha_pkg::OP_ALLOC, 24'd4, 24'd0, 1'b0);
    write_heap_length(24'hFFFFFF);
    send_req(bfha_pkg::OP_ALLOC, 24'hFFFFFF, 24'd0, 1'b0);
    send_req(bfha_pkg::OP_ALLOC, 24'hFFFFF0, 24'd0, 1'b0);
    send_req(bfha_pkg::OP_FREE, 24'd0, 24'd12, 1'b0);

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 79 : 0;
      rx_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 34 : 0;
      case ($urandom_range(3))
        0: len = 4096;
        1: len = 65536;
        2: len = $urandom_range(24'hFFFFFF);
        default: len = 24'hFFFFFF;
      endcase
      write_heap_length(24'(len));
      for (int i = 0; i < 250; i++) begin
        if (mode == 2 && i == 100) hold_req = 1;
        random_req(55);
      end
      write_heap_length(24'hFFFFFF);
      for (int i = 0; i < 280; i++) random_req(92);
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d requests over %0d heap sizes: ok %0d, invalid %0d, uninit %0d,",
             items_sent, configs_written, sb.status_seen[bfha_pkg::ST_OK],
             sb.status_seen[bfha_pkg::ST_INVALID], sb.status_seen[bfha_pkg::ST_UNINIT]);
    $display("no fit %0d, table full %0d; mismatches %0d",
             sb.status_seen[bfha_pkg::ST_NOFIT], sb.status_seen[bfha_pkg::ST_FULL], sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
